// ----- rtl/ptf_pkg.sv -----
// Shared types and constants of the periodic telemetry framer.
package ptf_pkg;

    localparam logic [7:0] HDR_BYTE0 = 8'hA5;
    localparam logic [7:0] HDR_BYTE1 = 8'h5A;
    localparam logic [7:0] HDR_BYTE2 = 8'h01;
    localparam logic [7:0] HDR_BYTE3 = 8'h83;
    localparam logic [7:0] FRAME_LEN = 8'd24;
    localparam logic [4:0] CRC_LEN   = 5'd22;
    localparam logic [4:0] LAST_IDX  = 5'd23;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] ACCEL_BAD = 16'h8000;

    localparam logic [9:0] ACCEL_SCALE = 10'd1000;
    localparam logic [9:0] RPM_SCALE   = 10'd10;

    typedef enum logic [1:0] {
        CFG_PERIOD    = 2'd0,
        CFG_ACCEL_AGE = 2'd1,
        CFG_ACCEL_NEG = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] period_ms;
        logic [15:0] accel_max_age_ms;
        logic        accel_negate;
    } t_cfg;

    typedef struct packed {
        logic        accel_valid;
        logic [7:0]  last_pressed;
        logic [7:0]  prev_button;
        logic [15:0] press_seq;
        logic [15:0] frame_seq;
        logic [31:0] now_ms;
        logic [15:0] accel;
        logic [15:0] left_rpm;
        logic [15:0] right_rpm;
    } t_frame_desc;

endpackage

// ----- rtl/ptf_front.sv -----
// Front end: tick acceptance, button tracking, frame scheduling and value scaling.
module ptf_front
    import ptf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [31:0]                    i_now_ms,
    input  logic [7:0]                     i_button_active,
    input  logic                           i_accel_present,
    input  logic [31:0]                    i_accel_stamp_ms,
    input  logic signed [31:0]             i_accel_x,
    input  logic signed [31:0]             i_left_rpm,
    input  logic signed [31:0]             i_right_rpm,
    input  logic [$clog2(DEPTH+1)-1:0]     i_queue_count,
    output logic                           o_push,
    output t_frame_desc                    o_push_desc
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NLANE = 3;

    // Negation on request, then sign and magnitude of the result.
    function automatic logic [32:0] sign_mag(input logic [31:0] v, input logic negate);
        logic signed [32:0] x;
        logic [32:0]        m;
        x = {v[31], v};
        if (negate) begin
            x = -x;
        end
        m = x[32] ? 33'(-x) : 33'(x);
        return {x[32], m[31:0]};
    endfunction

    // Rounds half away from zero and saturates to int16.
    function automatic logic [15:0] round_sat(input logic [41:0] prod, input logic neg);
        logic [42:0] sum;
        logic [26:0] r;
        sum = {1'b0, prod} + 43'd32768;
        r   = sum[42:16];
        if (neg) begin
            return (r >= 27'd32768) ? 16'h8000 : 16'(16'h0000 - r[15:0]);
        end
        return (r > 27'd32767) ? 16'h7FFF : r[15:0];
    endfunction

    logic        accept;
    logic        r_first_pending;
    logic [31:0] r_last_send;
    logic [15:0] r_frame_seq;
    logic [15:0] r_press_seq;
    logic [7:0]  r_prev_button;
    logic [7:0]  r_last_pressed;

    logic        n_pressed;
    logic [31:0] since_send;
    logic [31:0] period32;
    logic [31:0] lag_after;
    logic        send;
    logic [31:0] accel_age;

    logic               r_s1_valid;
    t_frame_desc        r_s1_desc;
    logic [NLANE-1:0][31:0] r_s1_raw;

    logic               r_s2_valid;
    t_frame_desc        r_s2_desc;
    logic [NLANE-1:0][31:0] r_s2_mag;
    logic [NLANE-1:0]   r_s2_neg;

    logic               r_s3_valid;
    t_frame_desc        r_s3_desc;
    logic [NLANE-1:0][41:0] r_s3_prod;
    logic [NLANE-1:0]   r_s3_neg;

    logic [CNT_W:0]     occupancy;
    logic [NLANE-1:0][9:0] lane_scale;

    assign lane_scale = {RPM_SCALE, RPM_SCALE, ACCEL_SCALE};

    assign occupancy = (CNT_W + 1)'(i_queue_count) + (CNT_W + 1)'(r_s1_valid)
                     + (CNT_W + 1)'(r_s2_valid) + (CNT_W + 1)'(r_s3_valid);
    assign o_stall   = occupancy >= (CNT_W + 1)'(DEPTH);
    assign accept    = i_valid && !o_stall;

    assign n_pressed  = (i_button_active != 8'd0) && (i_button_active != r_prev_button);
    assign period32   = {16'd0, i_cfg.period_ms};
    assign since_send = i_now_ms - r_last_send;
    assign lag_after  = since_send - period32;
    assign send       = r_first_pending || (since_send >= period32);
    assign accel_age  = i_now_ms - i_accel_stamp_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pending <= 1'b1;
            r_last_send     <= 32'd0;
            r_frame_seq     <= 16'd0;
            r_press_seq     <= 16'd0;
            r_prev_button   <= 8'd0;
            r_last_pressed  <= 8'd0;
            r_s1_valid      <= 1'b0;
            r_s2_valid      <= 1'b0;
            r_s3_valid      <= 1'b0;
        end else begin
            r_s1_valid <= accept && send;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (accept) begin
                r_prev_button <= i_button_active;
                if (n_pressed) begin
                    r_last_pressed <= i_button_active;
                    r_press_seq    <= r_press_seq + 16'd1;
                end
                if (send) begin
                    r_first_pending <= 1'b0;
                    r_frame_seq     <= r_frame_seq + 16'd1;
                    // The first tick always sends and leaves the schedule at now.
                    if (r_first_pending || (lag_after >= period32)) begin
                        r_last_send <= i_now_ms;
                    end else begin
                        r_last_send <= r_last_send + period32;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_desc.accel_valid  <= i_accel_present &&
                                      (accel_age <= {16'd0, i_cfg.accel_max_age_ms});
            r_s1_desc.last_pressed <= n_pressed ? i_button_active : r_last_pressed;
            r_s1_desc.prev_button  <= i_button_active;
            r_s1_desc.press_seq    <= n_pressed ? r_press_seq + 16'd1 : r_press_seq;
            r_s1_desc.frame_seq    <= r_frame_seq;
            r_s1_desc.now_ms       <= i_now_ms;
            r_s1_desc.accel        <= 16'd0;
            r_s1_desc.left_rpm     <= 16'd0;
            r_s1_desc.right_rpm    <= 16'd0;
            r_s1_raw[0]            <= i_accel_x;
            r_s1_raw[1]            <= i_left_rpm;
            r_s1_raw[2]            <= i_right_rpm;
        end
        r_s2_desc <= r_s1_desc;
        r_s3_desc <= r_s2_desc;
        for (int k = 0; k < NLANE; k++) begin
            {r_s2_neg[k], r_s2_mag[k]} <= sign_mag(r_s1_raw[k],
                                                   (k == 0) && i_cfg.accel_negate);
            r_s3_prod[k] <= 42'(r_s2_mag[k]) * 42'(lane_scale[k]);
            r_s3_neg[k]  <= r_s2_neg[k];
        end
    end

    always_comb begin
        o_push_desc           = r_s3_desc;
        o_push_desc.accel     = r_s3_desc.accel_valid ? round_sat(r_s3_prod[0], r_s3_neg[0])
                                                      : ACCEL_BAD;
        o_push_desc.left_rpm  = round_sat(r_s3_prod[1], r_s3_neg[1]);
        o_push_desc.right_rpm = round_sat(r_s3_prod[2], r_s3_neg[2]);
    end

    assign o_push = r_s3_valid;

endmodule

// ----- rtl/ptf_queue.sv -----
// Short descriptor queue between the front end and the byte serialiser.
module ptf_queue
    import ptf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_frame_desc                i_push_desc,
    input  logic                       i_pop,
    output t_frame_desc                o_head,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_desc      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < CNT_W'(DEPTH))
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("descriptor queue popped while empty");

endmodule

// ----- rtl/ptf_back.sv -----
// Back end: serialises one frame descriptor into 24 bytes with a running CRC.
module ptf_back
    import ptf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_desc i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic [4:0]  o_byte_index,
    output logic        o_last_byte
);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic        r_active;
    t_frame_desc r_desc;
    logic [4:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [4:0]  r_out_index;
    logic        r_out_last;
    logic        load;
    logic [7:0]  cur_byte;

    assign load  = r_active && (!r_out_valid || !i_stall);
    assign o_pop = !i_empty && (!r_active || (load && (r_idx == LAST_IDX)));

    always_comb begin
        unique case (r_idx)
            5'd0:    cur_byte = HDR_BYTE0;
            5'd1:    cur_byte = HDR_BYTE1;
            5'd2:    cur_byte = HDR_BYTE2;
            5'd3:    cur_byte = HDR_BYTE3;
            5'd4:    cur_byte = FRAME_LEN;
            5'd5:    cur_byte = {7'd0, r_desc.accel_valid};
            5'd6:    cur_byte = r_desc.last_pressed;
            5'd7:    cur_byte = r_desc.prev_button;
            5'd8:    cur_byte = r_desc.press_seq[7:0];
            5'd9:    cur_byte = r_desc.press_seq[15:8];
            5'd10:   cur_byte = r_desc.frame_seq[7:0];
            5'd11:   cur_byte = r_desc.frame_seq[15:8];
            5'd12:   cur_byte = r_desc.now_ms[7:0];
            5'd13:   cur_byte = r_desc.now_ms[15:8];
            5'd14:   cur_byte = r_desc.now_ms[23:16];
            5'd15:   cur_byte = r_desc.now_ms[31:24];
            5'd16:   cur_byte = r_desc.accel[7:0];
            5'd17:   cur_byte = r_desc.accel[15:8];
            5'd18:   cur_byte = r_desc.left_rpm[7:0];
            5'd19:   cur_byte = r_desc.left_rpm[15:8];
            5'd20:   cur_byte = r_desc.right_rpm[7:0];
            5'd21:   cur_byte = r_desc.right_rpm[15:8];
            5'd22:   cur_byte = r_crc[7:0];
            5'd23:   cur_byte = r_crc[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 5'd1;
                if (r_idx == LAST_IDX) begin
                    r_active <= 1'b0;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_active <= 1'b1;
                r_idx    <= 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte  <= cur_byte;
            r_out_index <= r_idx;
            r_out_last  <= (r_idx == LAST_IDX);
            if (r_idx < CRC_LEN) begin
                r_crc <= crc_byte(r_crc, cur_byte);
            end
        end
        if (o_pop) begin
            r_desc <= i_head;
            r_crc  <= CRC_INIT;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_byte_index = r_out_index;
    assign o_last_byte  = r_out_last;

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_byte |-> o_byte_index == LAST_IDX)
        else $error("last byte flagged away from the CRC high byte");

    a_frame_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_byte |=>
            o_valid && (o_byte_index == 5'($past(o_byte_index) + 5'd1)))
        else $error("frame bytes not contiguous");

    a_header_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_byte_index == 5'd0) |-> o_frame_byte == HDR_BYTE0)
        else $error("frame does not open with the header");

endmodule

// ----- rtl/periodic_telemetry_framer_core.sv -----
// Top level of the periodic telemetry framer: configuration registers and block wiring.
//
// One input transaction is one millisecond tick. The block tracks button presses on every
// tick and, when the period scheduler fires, emits a 24-byte telemetry frame as 24 output
// transactions, one byte each, indices 0 to 23, with the last byte flagged; the final two
// bytes are the little-endian CRC16-CCITT-FALSE of bytes 0 to 21. Ticks are taken one per
// cycle while the descriptor queue has room; the front end passes a frame through its
// capture, sign and magnitude, and multiply stages before pushing it into the queue. The
// serialiser moves one byte per cycle while the output is not stalled and takes up the
// next frame only after the last byte of the current one, and up to QUEUE_DEPTH frames
// (including those in the front pipeline) may wait.
// Configuration is written through a simple write port and must only change while the
// block is idle.
module periodic_telemetry_framer_core
    import ptf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_now_ms,
    input  logic [7:0]         i_button_active,
    input  logic               i_accel_present,
    input  logic [31:0]        i_accel_stamp_ms,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_left_rpm,
    input  logic signed [31:0] i_right_rpm,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_frame_byte,
    output logic [4:0]         o_byte_index,
    output logic               o_last_byte
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers; an index beyond the list is simply ignored.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ms        <= 16'd10;
            r_cfg.accel_max_age_ms <= 16'd100;
            r_cfg.accel_negate     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD:    r_cfg.period_ms        <= i_cfg_data;
                CFG_ACCEL_AGE: r_cfg.accel_max_age_ms <= i_cfg_data;
                CFG_ACCEL_NEG: r_cfg.accel_negate     <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Descriptors of frames to send travel from the front end through the queue to the
    // serialiser, so a stalled output never holds up tick acceptance until the queue fills.
    logic             push;
    t_frame_desc      push_desc;
    logic             pop;
    t_frame_desc      head;
    logic             empty;
    logic [CNT_W-1:0] queue_count;

    ptf_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_now_ms        (i_now_ms),
        .i_button_active (i_button_active),
        .i_accel_present (i_accel_present),
        .i_accel_stamp_ms(i_accel_stamp_ms),
        .i_accel_x       (i_accel_x),
        .i_left_rpm      (i_left_rpm),
        .i_right_rpm     (i_right_rpm),
        .i_queue_count   (queue_count),
        .o_push          (push),
        .o_push_desc     (push_desc)
    );

    ptf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_desc(push_desc),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (empty),
        .o_count    (queue_count)
    );

    ptf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_frame_byte(o_frame_byte),
        .o_byte_index(o_byte_index),
        .o_last_byte (o_last_byte)
    );

endmodule
